>>> src/tkch_pkg.sv
// ----------------------------------------------------------------------------
// tkch_pkg
// types, constants and hash helpers for the tuple-key chained hash table
// ----------------------------------------------------------------------------
package tkch_pkg;

  localparam int unsigned KeyWordsDef   = 4;
  localparam int unsigned CapacityDef   = 1024;
  localparam int unsigned MaxBucketsDef = 1024;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvMult  = 32'd16777619;

  localparam logic [3:0] BucketBitsRst = 4'd10;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_READ_OK   = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key_word0;
    logic [31:0] key_word1;
    logic [31:0] key_word2;
    logic [31:0] key_word3;
    logic [63:0] new_value;
    logic [9:0]  entry_select;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  entry_number;
    logic [9:0]  bucket_index;
    logic [63:0] read_value;
  } rsp_t;

  typedef enum logic [3:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_HASH,
    BK_HEAD,
    BK_HEAD_WAIT,
    BK_ENTRY,
    BK_ENTRY_WAIT,
    BK_LINK,
    BK_VALUE,
    BK_VALUE_WAIT,
    BK_DONE
  } back_state_e;

  // one fnv-1a byte step: xor then multiply
  function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FnvMult;
  endfunction

endpackage

>>> src/tkch_front.sv
// ----------------------------------------------------------------------------
// tkch_front
// two-entry request queue feeding the table engine
// ----------------------------------------------------------------------------
module tkch_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tkch_pkg::req_t  in_data_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output tkch_pkg::req_t  q_data_o
);

  tkch_pkg::req_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

>>> src/tkch_back.sv
// ----------------------------------------------------------------------------
// tkch_back
// hashing, chain walk and table update engine with result register
// ----------------------------------------------------------------------------
module tkch_back #(
  parameter int unsigned KEY_WORDS   = tkch_pkg::KeyWordsDef,
  parameter int unsigned CAPACITY    = tkch_pkg::CapacityDef,
  parameter int unsigned MAX_BUCKETS = tkch_pkg::MaxBucketsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [3:0]      bucket_bits_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  tkch_pkg::req_t  q_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tkch_pkg::rsp_t  out_data_o
);

  localparam int unsigned EW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned MBB = $clog2(MAX_BUCKETS + 1) - 1;
  localparam int unsigned KB  = KEY_WORDS * 32;
  localparam int unsigned BYTES = KEY_WORDS * 4;
  localparam int unsigned BCW = $clog2(BYTES + 1);

  // storage, bucket heads carry a valid bit on top
  logic [EW:0]     head_mem   [MAX_BUCKETS];
  logic [EW:0]     link_mem   [CAPACITY];
  logic [KB-1:0]   key_mem    [CAPACITY];
  logic [63:0]     value_mem  [CAPACITY];

  tkch_pkg::back_state_e state_q, state_d;

  tkch_pkg::req_t  req_q;
  logic [31:0]     hash_q;
  logic [BCW-1:0]  byte_q;
  logic [BW-1:0]   bucket_q;
  logic [BW-1:0]   clr_q;
  logic [EW-1:0]   cur_q, last_q;
  logic            nonempty_q, found_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   steps_q;

  logic [EW:0]     head_rd_q;
  logic [EW:0]     link_rd_q;
  logic [KB-1:0]   key_rd_q;
  logic [63:0]     value_rd_q;

  logic            out_valid_q;
  tkch_pkg::rsp_t  res_q;
  tkch_pkg::rsp_t  out_q;

  logic [KB-1:0]   req_key;
  logic [7:0]      cur_byte;
  logic [3:0]      eff_bits;
  logic [BW-1:0]   bucket_mask;
  logic            key_hit;
  logic [EW-1:0]   sel_idx;

  always_comb begin
    logic [127:0] rk;
    logic [6:0]   bofs;
    rk = {req_q.key_word3, req_q.key_word2, req_q.key_word1, req_q.key_word0};
    bofs = 7'(byte_q) << 3;
    req_key  = rk[KB-1:0];
    cur_byte = rk[bofs +: 8];
  end

  assign eff_bits = ({1'b0, bucket_bits_i} > 5'(MBB)) ? 4'(MBB) : bucket_bits_i;
  always_comb begin
    logic [31:0] m;
    m = (32'd1 << eff_bits) - 32'd1;
    bucket_mask = m[BW-1:0];
  end

  assign key_hit = (key_rd_q == req_key);
  assign sel_idx = EW'(req_q.entry_select);

  assign q_pop_o     = (state_q == tkch_pkg::BK_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tkch_pkg::BK_CLEAR: begin
        if (clr_q == BW'(MAX_BUCKETS - 1)) state_d = tkch_pkg::BK_IDLE;
      end
      tkch_pkg::BK_IDLE: begin
        if (q_valid_i) state_d = tkch_pkg::BK_HASH;
      end
      tkch_pkg::BK_HASH: begin
        if (req_q.kind == tkch_pkg::KIND_READ) begin
          state_d = ({{(32-CW){1'b0}}, count_q} > {22'd0, req_q.entry_select})
                    ? tkch_pkg::BK_VALUE : tkch_pkg::BK_DONE;
        end else if (req_q.kind == tkch_pkg::KIND_NONE) begin
          state_d = tkch_pkg::BK_DONE;
        end else if (byte_q == BCW'(BYTES)) begin
          state_d = tkch_pkg::BK_HEAD;
        end
      end
      tkch_pkg::BK_HEAD:      state_d = tkch_pkg::BK_HEAD_WAIT;
      tkch_pkg::BK_HEAD_WAIT: state_d = head_rd_q[EW] ? tkch_pkg::BK_ENTRY : tkch_pkg::BK_LINK;
      tkch_pkg::BK_ENTRY: begin
        if (CW'(cur_q) >= count_q || steps_q > count_q) state_d = tkch_pkg::BK_LINK;
        else state_d = tkch_pkg::BK_ENTRY_WAIT;
      end
      tkch_pkg::BK_ENTRY_WAIT: begin
        if (key_hit) state_d = (req_q.kind == tkch_pkg::KIND_FIND)
                               ? tkch_pkg::BK_VALUE : tkch_pkg::BK_DONE;
        else if (!link_rd_q[EW]) state_d = tkch_pkg::BK_LINK;
        else state_d = tkch_pkg::BK_ENTRY;
      end
      tkch_pkg::BK_LINK:       state_d = tkch_pkg::BK_DONE;
      tkch_pkg::BK_VALUE:      state_d = tkch_pkg::BK_VALUE_WAIT;
      tkch_pkg::BK_VALUE_WAIT: state_d = tkch_pkg::BK_DONE;
      tkch_pkg::BK_DONE: begin
        if (!out_valid_q || !out_stall_i) state_d = tkch_pkg::BK_IDLE;
      end
      default: state_d = tkch_pkg::BK_IDLE;
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    head_rd_q <= head_mem[bucket_q];
    if (state_q == tkch_pkg::BK_CLEAR) begin
      head_mem[clr_q] <= '0;
    end else if (state_q == tkch_pkg::BK_LINK && !found_q
                 && req_q.kind == tkch_pkg::KIND_INSERT
                 && count_q < CW'(CAPACITY) && !nonempty_q) begin
      head_mem[bucket_q] <= {1'b1, count_q[EW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[cur_q];
    link_rd_q <= link_mem[cur_q];
    if (state_q == tkch_pkg::BK_LINK && !found_q && req_q.kind == tkch_pkg::KIND_INSERT
        && count_q < CW'(CAPACITY)) begin
      key_mem[count_q[EW-1:0]]  <= req_key;
    end
  end

  always_ff @(posedge clk_i) begin
    logic ins;
    ins = state_q == tkch_pkg::BK_LINK && !found_q && req_q.kind == tkch_pkg::KIND_INSERT
          && count_q < CW'(CAPACITY);
    if (ins) begin
      link_mem[count_q[EW-1:0]] <= '0;
    end else if (state_q == tkch_pkg::BK_DONE && req_q.kind == tkch_pkg::KIND_INSERT
                 && res_q.status == tkch_pkg::ST_INSERTED && nonempty_q
                 && (!out_valid_q || !out_stall_i)) begin
      link_mem[last_q] <= {1'b1, cur_q};
    end
  end

  always_ff @(posedge clk_i) begin
    value_rd_q <= value_mem[(req_q.kind == tkch_pkg::KIND_READ) ? sel_idx : cur_q];
    if (state_q == tkch_pkg::BK_LINK && !found_q && req_q.kind == tkch_pkg::KIND_INSERT
        && count_q < CW'(CAPACITY)) begin
      value_mem[count_q[EW-1:0]] <= req_q.new_value;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tkch_pkg::BK_IDLE: begin
        req_q  <= q_data_i;
        hash_q <= tkch_pkg::FnvBasis;
        byte_q <= '0;
      end
      tkch_pkg::BK_HASH: begin
        if (byte_q != BCW'(BYTES)) begin
          hash_q <= tkch_pkg::fnv_step(hash_q, cur_byte);
          byte_q <= byte_q + 1'b1;
        end else begin
          bucket_q <= hash_q[BW-1:0] & bucket_mask;
        end
        found_q    <= 1'b0;
        steps_q    <= '0;
        nonempty_q <= 1'b0;
      end
      tkch_pkg::BK_HEAD_WAIT: begin
        nonempty_q <= head_rd_q[EW];
        cur_q      <= head_rd_q[EW-1:0];
      end
      tkch_pkg::BK_ENTRY: steps_q <= steps_q + 1'b1;
      tkch_pkg::BK_ENTRY_WAIT: begin
        if (key_hit) found_q <= 1'b1;
        else begin
          last_q <= cur_q;
          cur_q  <= link_rd_q[EW-1:0];
        end
      end
      tkch_pkg::BK_LINK: cur_q <= count_q[EW-1:0];
      default: ;
    endcase
  end

  // result and bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkch_pkg::BK_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_q == tkch_pkg::BK_HASH && req_q.kind != tkch_pkg::KIND_READ
                 && req_q.kind != tkch_pkg::KIND_NONE && byte_q != BCW'(BYTES)
                 ? state_q : state_d;
      if (state_q == tkch_pkg::BK_CLEAR) clr_q <= clr_q + 1'b1;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (state_q == tkch_pkg::BK_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end
      if (state_q == tkch_pkg::BK_LINK && !found_q && req_q.kind == tkch_pkg::KIND_INSERT
          && count_q < CW'(CAPACITY)) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tkch_pkg::BK_HASH: begin
        res_q <= '{status: tkch_pkg::ST_NOT_FOUND, entry_number: '0,
                   bucket_index: '0, read_value: '0};
      end
      tkch_pkg::BK_HEAD: res_q.bucket_index <= 10'(bucket_q);
      tkch_pkg::BK_ENTRY_WAIT: begin
        if (key_hit) begin
          if (req_q.kind == tkch_pkg::KIND_FIND) begin
            res_q.status       <= tkch_pkg::ST_FOUND;
            res_q.entry_number <= 10'(cur_q);
          end else begin
            res_q.status <= tkch_pkg::ST_DUPLICATE;
          end
        end
      end
      tkch_pkg::BK_LINK: begin
        if (req_q.kind == tkch_pkg::KIND_INSERT) begin
          if (count_q >= CW'(CAPACITY)) res_q.status <= tkch_pkg::ST_FULL;
          else begin
            res_q.status       <= tkch_pkg::ST_INSERTED;
            res_q.entry_number <= 10'(count_q);
          end
        end
      end
      tkch_pkg::BK_VALUE_WAIT: begin
        res_q.read_value <= value_rd_q;
        if (req_q.kind == tkch_pkg::KIND_READ) begin
          res_q.status       <= tkch_pkg::ST_READ_OK;
          res_q.entry_number <= req_q.entry_select;
        end
      end
      default: ;
    endcase
  end

  // output register, loaded only when the previous result has left
  always_ff @(posedge clk_i) begin
    if (state_q == tkch_pkg::BK_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

endmodule

>>> src/tuple_key_chained_hash_table.sv
// ----------------------------------------------------------------------------
// tuple_key_chained_hash_table
// fnv-1a hashed tuple-key map with separate chaining and apb configuration
// ----------------------------------------------------------------------------
// channel  | direction | handshake           | payload
// in       | input     | in_valid/in_stall   | tkch_pkg::req_t
// out      | output    | out_valid/out_stall | tkch_pkg::rsp_t
// cfg      | input     | apb write/read      | bucket_bits at address 0
//
// one request at a time: pop, hash over every key byte, head read, a read per chain
// entry visited, then update or value read and result
// reads and unused kinds skip the hash and the chain walk
// after reset a clearing pass empties all MAX_BUCKETS bucket heads
// a two-deep queue takes requests while the engine works
// the engine waits in its done state while a stalled result is still held
module tuple_key_chained_hash_table #(
  parameter int unsigned KEY_WORDS   = tkch_pkg::KeyWordsDef,
  parameter int unsigned CAPACITY    = tkch_pkg::CapacityDef,
  parameter int unsigned MAX_BUCKETS = tkch_pkg::MaxBucketsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tkch_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tkch_pkg::rsp_t  out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [1:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  logic [3:0]     bucket_bits_q;
  logic           q_valid, q_pop;
  tkch_pkg::req_t q_data;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {28'd0, bucket_bits_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_bits_q <= tkch_pkg::BucketBitsRst;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      bucket_bits_q <= pwdata[3:0];
    end
  end

  tkch_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  tkch_back #(
    .KEY_WORDS(KEY_WORDS), .CAPACITY(CAPACITY), .MAX_BUCKETS(MAX_BUCKETS)
  ) u_back (
    .clk_i, .rst_ni, .bucket_bits_i(bucket_bits_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

>>> src/tkch_checker.sv
// ----------------------------------------------------------------------------
// tkch_checker
// port-level checks for the hash table, bound to the top level
// ----------------------------------------------------------------------------
module tkch_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tkch_pkg::rsp_t out_data_o,
  input logic           pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= tkch_pkg::ST_READ_OK)
    else $error("status out of range");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != tkch_pkg::ST_FOUND
    && out_data_o.status != tkch_pkg::ST_READ_OK |-> out_data_o.read_value == 64'd0)
    else $error("value on result without data");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind tuple_key_chained_hash_table tkch_checker u_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_data_o, .pready
);
